// ===== hdl/hot_water_charge_controller_macros.svh =====
// Assertion macros used by the hot water charge controller checker.
`ifndef HOT_WATER_CHARGE_CONTROLLER_MACROS_SVH
`define HOT_WATER_CHARGE_CONTROLLER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HWCC_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hwcc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define HWCC_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hwcc assertion failed");

`endif

// ===== hdl/hwcc_pkg.sv =====
// Types, codes and constants of the hot water charge controller.
`timescale 1ns / 1ps

package hwcc_pkg;

	// Temperatures are signed integers in 1/TEMP_SCALE degree.
	localparam int TEMP_SCALE = 10;
	localparam int DELTA_MIN = 5 * TEMP_SCALE;
	localparam int DELTA_MAX = 20 * TEMP_SCALE;
	localparam int DELTA_DEFAULT = 10 * TEMP_SCALE;
	localparam int RESET_MIN_DIFF = TEMP_SCALE;

	// Configuration port geometry.
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_DELTA = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_BELOW = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STOP_ABOVE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_MIN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_MAX = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_REFRESH_PERIOD = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_AUTOTUNE_PERIOD = 3'd6;

	// Action codes of a result item.
	typedef enum logic [2:0] {
		ACT_NONE    = 3'd0,
		ACT_START   = 3'd1,
		ACT_STOP    = 3'd2,
		ACT_YIELD   = 3'd3,
		ACT_REFRESH = 3'd4
	} act_t;

	// Configuration register set.
	typedef struct packed {
		logic [9:0]         charge_delta;
		logic signed [11:0] start_below;
		logic signed [11:0] stop_above;
		logic signed [11:0] target_min;
		logic signed [11:0] target_max;
		logic [31:0]        refresh_period_ms;
		logic [31:0]        autotune_period_ms;
	} cfg_t;

	// One input item.
	typedef struct packed {
		logic               op;
		logic signed [11:0] tank_temp;
		logic               tank_valid;
		logic               sensors_ok;
		logic               boiler_en;
		logic               dhw_en;
		logic               dhw_first;
		logic               heating_active;
		logic [1:0]         override_bits;
		logic [1:0]         burner_bits;
		logic               autotune_active;
		logic [31:0]        now_ms;
	} item_t;

	// One result item.
	typedef struct packed {
		act_t               action;
		logic signed [11:0] boiler_target;
		logic               water_active;
		logic               demand;
	} result_t;

endpackage

// ===== hdl/hwcc_cfg_regs.sv =====
// Configuration register file of the hot water charge controller.
`timescale 1ns / 1ps

module hwcc_cfg_regs
	import hwcc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	// Write one register per enabled cycle; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.charge_delta       <= 10'd100;
			cfg_q.start_below        <= 12'sd450;
			cfg_q.stop_above         <= 12'sd550;
			cfg_q.target_min         <= 12'sd400;
			cfg_q.target_max         <= 12'sd900;
			cfg_q.refresh_period_ms  <= 32'd300000;
			cfg_q.autotune_period_ms <= 32'd60000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CHARGE_DELTA:    cfg_q.charge_delta       <= cfg_data[9:0];
				CFG_START_BELOW:     cfg_q.start_below        <= signed'(cfg_data[11:0]);
				CFG_STOP_ABOVE:      cfg_q.stop_above         <= signed'(cfg_data[11:0]);
				CFG_TARGET_MIN:      cfg_q.target_min         <= signed'(cfg_data[11:0]);
				CFG_TARGET_MAX:      cfg_q.target_max         <= signed'(cfg_data[11:0]);
				CFG_REFRESH_PERIOD:  cfg_q.refresh_period_ms  <= cfg_data[31:0];
				CFG_AUTOTUNE_PERIOD: cfg_q.autotune_period_ms <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hdl/hwcc_core.sv =====
// Mode, demand latch, target and timer logic of the hot water charge controller.
`timescale 1ns / 1ps

module hwcc_core
	import hwcc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  item_t   item,
	input  logic    fire,
	output result_t result
);

	logic               mode_q, mode_d;
	logic               demand_q, demand_d;
	logic signed [11:0] held_q, held_d;
	logic [31:0]        refresh_stamp_q, refresh_stamp_d;
	logic [31:0]        autotune_stamp_q, autotune_stamp_d;

	logic               thr_ok;
	logic               latch_eval;
	logic               need;
	logic [9:0]         delta;
	logic signed [12:0] sum;
	logic signed [12:0] clamp_lo;
	logic signed [11:0] calc_target;
	logic signed [12:0] diff;
	logic               diff_big;
	logic [31:0]        refresh_elapsed;
	logic [31:0]        autotune_elapsed;
	logic               force_on, force_off, water_req, heat_req;
	act_t               act;
	logic signed [11:0] tgt;

	assign force_on  = item.override_bits[0];
	assign force_off = item.override_bits[1];
	assign water_req = item.burner_bits[0];
	assign heat_req  = item.burner_bits[1];

	// Hysteresis latch: only updates when the reading and thresholds are usable.
	always_comb begin
		thr_ok = item.tank_valid && (cfg.start_below > 12'sd0) && (cfg.stop_above > 12'sd0);
		latch_eval = demand_q;
		if (thr_ok) begin
			if (!demand_q && (item.tank_temp < cfg.start_below)) begin
				latch_eval = 1'b1;
			end else if (demand_q && (item.tank_temp > cfg.stop_above)) begin
				latch_eval = 1'b0;
			end
		end
		need = thr_ok && latch_eval;
	end

	// Boiler target: tank plus validated delta, clamped low then high.
	always_comb begin
		if ((cfg.charge_delta < 10'(DELTA_MIN)) || (cfg.charge_delta > 10'(DELTA_MAX))) begin
			delta = 10'(DELTA_DEFAULT);
		end else begin
			delta = cfg.charge_delta;
		end
		sum = 13'(item.tank_temp) + signed'({3'b000, delta});
		clamp_lo = (sum < 13'(cfg.target_min)) ? 13'(cfg.target_min) : sum;
		calc_target = (clamp_lo > 13'(cfg.target_max)) ? cfg.target_max : clamp_lo[11:0];
	end

	// Change detection and wrapping timers.
	always_comb begin
		diff = 13'(calc_target) - 13'(held_q);
		diff_big = (diff > 13'sd0 + 13'(RESET_MIN_DIFF)) ||
			(diff < 13'sd0 - 13'(RESET_MIN_DIFF));
		refresh_elapsed  = item.now_ms - refresh_stamp_q;
		autotune_elapsed = item.now_ms - autotune_stamp_q;
	end

	// Decision for one item.
	always_comb begin
		act = ACT_NONE;
		tgt = 12'sd0;
		mode_d = mode_q;
		demand_d = demand_q;
		held_d = held_q;
		refresh_stamp_d = refresh_stamp_q;
		autotune_stamp_d = autotune_stamp_q;
		if (item.op) begin
			if (mode_q && !item.sensors_ok) begin
				act = ACT_STOP;
				mode_d = 1'b0;
			end
		end else if (!item.boiler_en || !item.dhw_en) begin
			if (mode_q) begin
				act = ACT_STOP;
				mode_d = 1'b0;
			end
		end else if (!mode_q) begin
			demand_d = latch_eval;
			if ((need || force_on) && item.sensors_ok &&
				(item.dhw_first || !item.heating_active)) begin
				act = ACT_START;
				tgt = calc_target;
				held_d = calc_target;
				mode_d = 1'b1;
			end
		end else begin
			demand_d = latch_eval;
			if (!water_req && heat_req) begin
				act = ACT_YIELD;
				mode_d = 1'b0;
			end else if (force_off || !need || !item.sensors_ok) begin
				act = ACT_STOP;
				mode_d = 1'b0;
			end else if (item.autotune_active) begin
				if (autotune_elapsed > cfg.autotune_period_ms) begin
					act = ACT_REFRESH;
					tgt = held_q;
					autotune_stamp_d = item.now_ms;
				end
			end else if (diff_big || (refresh_elapsed > cfg.refresh_period_ms)) begin
				act = ACT_REFRESH;
				tgt = calc_target;
				held_d = calc_target;
				refresh_stamp_d = item.now_ms;
			end
		end
	end

	// State advances once per item that moves to the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			demand_q <= 1'b0;
			held_q <= 12'sd0;
			refresh_stamp_q <= 32'd0;
			autotune_stamp_q <= 32'd0;
		end else if (fire) begin
			mode_q <= mode_d;
			demand_q <= demand_d;
			held_q <= held_d;
			refresh_stamp_q <= refresh_stamp_d;
			autotune_stamp_q <= autotune_stamp_d;
		end
	end

	assign result.action = act;
	assign result.boiler_target = tgt;
	assign result.water_active = mode_d;
	assign result.demand = demand_d;

endmodule

// ===== hdl/hot_water_charge_controller.sv =====
// Top level of the hot water charge controller.
//
// Input channel: in_valid / in_stall with one port per field; an item is
// taken at a clock edge with in_valid high and in_stall low. Output channel:
// out_valid / out_stall; a result is taken at an edge with out_valid high
// and out_stall low. Every input item yields exactly one result item.
// A taken item lands in the input register. When the result register is
// free, its result is written there and the mode, demand latch, held target
// and timer stamps are updated.
// Throughput is one item per cycle while out_stall is low, set by the single
// pass through the decision logic between the input and result registers.
// When the receiver stalls, the result holds and the input register keeps
// one more item; in_stall rises only when both are full.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data); write
// it only while no item is in flight.
// Reset clears both registers' valid flags, sets the mode off, the latch
// clear, the held target and stamps to zero and the registers to defaults.
`timescale 1ns / 1ps

module hot_water_charge_controller
	import hwcc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  op,
	input  logic signed [11:0]    tank_temp,
	input  logic                  tank_valid,
	input  logic                  sensors_ok,
	input  logic                  boiler_en,
	input  logic                  dhw_en,
	input  logic                  dhw_first,
	input  logic                  heating_active,
	input  logic [1:0]            override_bits,
	input  logic [1:0]            burner_bits,
	input  logic                  autotune_active,
	input  logic [31:0]           now_ms,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [2:0]            action,
	output logic signed [11:0]    boiler_target,
	output logic                  water_active,
	output logic                  demand
);

	cfg_t    cfg;
	item_t   item_in;
	item_t   item_s1;
	logic    valid_s1;
	result_t result_comb;
	result_t result_s2;
	logic    valid_s2;
	logic    advance;
	logic    fire;

	hwcc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Gather the input fields into one item.
	assign item_in = '{
		op:              op,
		tank_temp:       tank_temp,
		tank_valid:      tank_valid,
		sensors_ok:      sensors_ok,
		boiler_en:       boiler_en,
		dhw_en:          dhw_en,
		dhw_first:       dhw_first,
		heating_active:  heating_active,
		override_bits:   override_bits,
		burner_bits:     burner_bits,
		autotune_active: autotune_active,
		now_ms:          now_ms
	};

	// The result register frees up when it is empty or being taken.
	assign advance  = !valid_s2 || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= item_in;
		end
	end

	hwcc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item_s1),
		.fire   (fire),
		.result (result_comb)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_s2 <= result_comb;
		end
	end

	assign out_valid     = valid_s2;
	assign action        = result_s2.action;
	assign boiler_target = result_s2.boiler_target;
	assign water_active  = result_s2.water_active;
	assign demand        = result_s2.demand;

endmodule

// ===== hdl/hwcc_checker.sv =====
// Port-level checker of the hot water charge controller and its bind.
`timescale 1ns / 1ps
`include "hot_water_charge_controller_macros.svh"

module hwcc_checker
	import hwcc_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic [2:0]         action,
	input logic signed [11:0] boiler_target,
	input logic               water_active
);

	// A stalled result stays offered and unchanged.
	`HWCC_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(action) && $stable(boiler_target) && $stable(water_active))

	// Only start and refresh carry a target.
	`HWCC_ASSERT_IMP(a_target_zero, clk, arst_n, out_valid && (action == ACT_NONE || action == ACT_STOP || action == ACT_YIELD), boiler_target == 12'sd0)

	// Start and refresh leave the mode on.
	`HWCC_ASSERT_IMP(a_on_after, clk, arst_n, out_valid && (action == ACT_START || action == ACT_REFRESH), water_active)

	// Stop and yield leave the mode off.
	`HWCC_ASSERT_IMP(a_off_after, clk, arst_n, out_valid && (action == ACT_STOP || action == ACT_YIELD), !water_active)

endmodule

bind hot_water_charge_controller hwcc_checker u_hwcc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.action        (action),
	.boiler_target (boiler_target),
	.water_active  (water_active)
);
